// File: design/clb_pkg.sv
`timescale 1ns / 1ps

package clb_pkg;

  localparam int MaxCellsPerAxis = 16;
  localparam int CellCapacity    = 16;
  localparam int NumCells        = MaxCellsPerAxis * MaxCellsPerAxis * MaxCellsPerAxis;
  localparam int CellIdxW        = $clog2(NumCells);
  localparam int SlotW           = $clog2(CellCapacity);
  localparam int CountW          = SlotW + 1;
  localparam int RowCells        = 16;
  localparam int LaneW           = $clog2(RowCells);
  localparam int NumRows         = NumCells / RowCells;
  localparam int RowW            = CellIdxW - LaneW;
  localparam int MemAddrW        = CellIdxW + SlotW;
  localparam int CellsRegW       = 5;
  localparam int InvLenW         = 24;
  localparam int CoordW          = 4;
  localparam int ParticleW       = 16;
  localparam int CfgIdxW         = 3;
  localparam int CfgDataW        = 24;

  // Function codes of an input item
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_CELLS_X   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CELLS_Y   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CELLS_Z   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_INV_LEN_X = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_INV_LEN_Y = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_INV_LEN_Z = 3'd5;

  typedef struct packed {
    logic [1:0]           func;
    logic signed [31:0]   pos_x;
    logic signed [31:0]   pos_y;
    logic signed [31:0]   pos_z;
    logic [ParticleW-1:0] particle;
    logic [CellIdxW-1:0]  read_cell;
    logic [SlotW-1:0]     read_slot;
  } clb_in_t;

  typedef struct packed {
    logic [CoordW-1:0]    cell_x;
    logic [CoordW-1:0]    cell_y;
    logic [CoordW-1:0]    cell_z;
    logic [CellIdxW-1:0]  cell_index;
    logic [SlotW-1:0]     slot;
    logic [ParticleW-1:0] member;
    logic [CountW-1:0]    cell_count;
    logic [1:0]           status;
  } clb_out_t;

  typedef logic [RowCells-1:0][CountW-1:0] clb_cnt_row_t;

  // Clamp a cell count register to 1..MaxCellsPerAxis
  function automatic logic [CellsRegW-1:0] eff_cells(input logic [CellsRegW-1:0] c);
    logic [CellsRegW-1:0] n;
    n = c;
    if (c == '0) begin
      n = CellsRegW'(1);
    end else if (c > CellsRegW'(MaxCellsPerAxis)) begin
      n = CellsRegW'(MaxCellsPerAxis);
    end
    return n;
  endfunction

  // floor(2^24 / n): reciprocal used to reduce a 24-bit value modulo n
  function automatic logic [24:0] recip(input logic [CellsRegW-1:0] n);
    logic [24:0] m;
    unique case (n)
      5'd1:    m = 25'd16777216;
      5'd2:    m = 25'd8388608;
      5'd3:    m = 25'd5592405;
      5'd4:    m = 25'd4194304;
      5'd5:    m = 25'd3355443;
      5'd6:    m = 25'd2796202;
      5'd7:    m = 25'd2396745;
      5'd8:    m = 25'd2097152;
      5'd9:    m = 25'd1864135;
      5'd10:   m = 25'd1677721;
      5'd11:   m = 25'd1525201;
      5'd12:   m = 25'd1398101;
      5'd13:   m = 25'd1290555;
      5'd14:   m = 25'd1198372;
      5'd15:   m = 25'd1118481;
      5'd16:   m = 25'd1048576;
      default: m = 25'd16777216;
    endcase
    return m;
  endfunction

endpackage

// File: design/cell_list_binning_core.sv
`timescale 1ns / 1ps

// Cell-list binning for a periodic 3-D box. An insert transfer scales each
// Q15.16 position by the Q8.16 reciprocal cell length, adds the axis cell
// count, truncates and wraps modulo that count, forms the row-major cell index
// (z fastest) and appends the particle number to that cell's list of up to 16
// entries. A read transfer returns one list entry and the cell's count; a clear
// transfer empties every list at once. One result transfer follows every input
// transfer. All multiplies go through a single 32x26 multiplier under a small
// sequencer, so the block takes one item at a time. An insert runs through five
// sequencer steps per axis (three of them multiplier passes), two index
// multiplies, the count row read, the count write-back and the result hand-over.
// It stops early when the x, y or z scaled coordinate comes out negative. A read
// forms the cell total for the range check, reads the count row, checks address
// and slot and then reads the member, a step it skips when the address or slot
// is out of range; a clear or unused code goes straight to the hand-over. Input
// ready returns as soon as the result sits in the output register, even if that
// result is not yet taken. Cell counts live in a 256 x 80-bit memory with
// one valid bit per row of 16 cells, so no clearing pass is needed after reset
// or on clear. Configuration must only be written while the block is idle.
module cell_list_binning_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  clb_pkg::clb_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output clb_pkg::clb_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [clb_pkg::CfgIdxW-1:0]     cfg_idx,
  input  logic [clb_pkg::CfgDataW-1:0]    cfg_wdata
);
  import clb_pkg::*;

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;   // wait for an input transfer
  localparam logic [3:0] S_MPOS = 4'd1;   // position times reciprocal length
  localparam logic [3:0] S_ADD  = 4'd2;   // add cell count, check sign
  localparam logic [3:0] S_MREC = 4'd3;   // value times reciprocal of n
  localparam logic [3:0] S_MQN  = 4'd4;   // quotient estimate times n
  localparam logic [3:0] S_MOD  = 4'd5;   // remainder with one correction
  localparam logic [3:0] S_IX1  = 4'd6;   // cx * ny
  localparam logic [3:0] S_IX2  = 4'd7;   // (cx * ny + cy) * nz
  localparam logic [3:0] S_CRD  = 4'd8;   // form index, read count row
  localparam logic [3:0] S_CWR  = 4'd9;   // append and write count back
  localparam logic [3:0] S_RT1  = 4'd10;  // nx * ny for the range check
  localparam logic [3:0] S_RT2  = 4'd11;  // times nz
  localparam logic [3:0] S_RCMP = 4'd12;  // read count row of read_cell
  localparam logic [3:0] S_RCNT = 4'd13;  // check address and slot, read member
  localparam logic [3:0] S_RMEM = 4'd14;  // capture member
  localparam logic [3:0] S_DONE = 4'd15;  // hand result to output register

  // Configuration
  logic [CellsRegW-1:0] cells_x_r, cells_y_r, cells_z_r;
  logic [InvLenW-1:0]   inv_x_r, inv_y_r, inv_z_r;
  logic [CellsRegW-1:0] nx, ny, nz;

  // Sequencer and datapath
  logic [3:0]             state_r, state_nxt;
  clb_in_t                in_r;
  clb_out_t               res_r, res_nxt;
  logic [1:0]             axis_r, axis_nxt;
  logic [2:0][CoordW-1:0] coord_r, coord_nxt;
  logic [23:0]            v_r, v_nxt;
  logic [56:0]            prod_r;
  logic [CellIdxW-1:0]    idx_r, idx_nxt;
  logic                   out_valid_r;
  clb_out_t               out_r;

  // Shared multiplier
  logic signed [31:0] mul_a;
  logic [24:0]        mul_b;
  logic               mul_en;
  logic signed [57:0] mul_full;

  // Memories
  clb_cnt_row_t         cnt_mem [NumRows];
  clb_cnt_row_t         cnt_rd_r;
  clb_cnt_row_t         cnt_wdata;
  logic [RowW-1:0]      cnt_raddr;
  logic                 cnt_we;
  logic [NumRows-1:0]   row_vld_r, row_vld_nxt;
  logic [ParticleW-1:0] mem_r [2**MemAddrW];
  logic [ParticleW-1:0] mem_rd_r;
  logic [MemAddrW-1:0]  mem_addr;
  logic                 mem_we;

  // Per-axis operands
  logic signed [31:0]  pos_sel;
  logic [InvLenW-1:0]  inv_sel;
  logic [CellsRegW-1:0] n_sel;
  logic signed [25:0]  sum_ax;
  logic [23:0]         diff_ax;
  logic [5:0]          rem_ax;
  logic [CellIdxW-1:0] idx_c;
  logic [CellIdxW-1:0] cur_cell;
  logic [CountW-1:0]   cnt_cur;
  logic [7:0]          ix_part;

  assign nx = eff_cells(cells_x_r);
  assign ny = eff_cells(cells_y_r);
  assign nz = eff_cells(cells_z_r);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cells_x_r <= CellsRegW'(1);
      cells_y_r <= CellsRegW'(1);
      cells_z_r <= CellsRegW'(1);
      inv_x_r   <= InvLenW'(65536);
      inv_y_r   <= InvLenW'(65536);
      inv_z_r   <= InvLenW'(65536);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_CELLS_X:   cells_x_r <= cfg_wdata[CellsRegW-1:0];
        CFG_CELLS_Y:   cells_y_r <= cfg_wdata[CellsRegW-1:0];
        CFG_CELLS_Z:   cells_z_r <= cfg_wdata[CellsRegW-1:0];
        CFG_INV_LEN_X: inv_x_r   <= cfg_wdata[InvLenW-1:0];
        CFG_INV_LEN_Y: inv_y_r   <= cfg_wdata[InvLenW-1:0];
        CFG_INV_LEN_Z: inv_z_r   <= cfg_wdata[InvLenW-1:0];
        default: ;
      endcase
    end
  end

  // Select the operands of the axis in work
  always_comb begin
    case (axis_r)
      2'd0: begin
        pos_sel = in_r.pos_x;
        inv_sel = inv_x_r;
        n_sel   = nx;
      end
      2'd1: begin
        pos_sel = in_r.pos_y;
        inv_sel = inv_y_r;
        n_sel   = ny;
      end
      default: begin
        pos_sel = in_r.pos_z;
        inv_sel = inv_z_r;
        n_sel   = nz;
      end
    endcase
  end

  // Integer part of the scaled position plus n; the fraction is never
  // negative, so the sign of this sum is the sign of the full Q23.32 sum.
  assign sum_ax  = {{2{prod_r[55]}}, prod_r[55:32]} + {21'b0, n_sel};
  // Remainder estimate stays below 2n, so one subtract finishes it
  assign diff_ax = v_r - prod_r[23:0];
  assign rem_ax  = diff_ax[5:0];

  assign ix_part = prod_r[7:0] + {4'b0, coord_r[1]};
  assign idx_c   = prod_r[CellIdxW-1:0] + {8'b0, coord_r[2]};

  // Count of the addressed cell; a row that has not been written since the
  // last clear reads as all zero.
  assign cur_cell = (state_r == S_CWR) ? idx_r : in_r.read_cell;
  assign cnt_cur  = row_vld_r[cur_cell[CellIdxW-1:LaneW]] ?
                    cnt_rd_r[cur_cell[LaneW-1:0]] : '0;

  // Shared multiplier operand selection
  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (state_r)
      S_MPOS: begin
        mul_a = pos_sel;
        mul_b = {1'b0, inv_sel};
      end
      S_MREC: begin
        mul_a = {8'b0, v_r};
        mul_b = recip(n_sel);
      end
      S_MQN: begin
        mul_a = {8'b0, prod_r[47:24]};
        mul_b = {20'b0, n_sel};
      end
      S_IX1: begin
        mul_a = {28'b0, coord_r[0]};
        mul_b = {20'b0, ny};
      end
      S_IX2: begin
        mul_a = {24'b0, ix_part};
        mul_b = {20'b0, nz};
      end
      S_RT1: begin
        mul_a = {27'b0, nx};
        mul_b = {20'b0, ny};
      end
      S_RT2: begin
        mul_a = {23'b0, prod_r[8:0]};
        mul_b = {20'b0, nz};
      end
      default: mul_en = 1'b0;
    endcase
  end

  assign mul_full = mul_a * $signed({1'b0, mul_b});

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_full[56:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    res_nxt     = res_r;
    axis_nxt    = axis_r;
    coord_nxt   = coord_r;
    v_nxt       = v_r;
    idx_nxt     = idx_r;
    row_vld_nxt = row_vld_r;
    cnt_raddr   = in_r.read_cell[CellIdxW-1:LaneW];
    cnt_we      = 1'b0;
    cnt_wdata   = '0;
    mem_addr    = {in_r.read_cell, in_r.read_slot};
    mem_we      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt  = '0;
          axis_nxt = 2'd0;
          unique case (in_data.func)
            FUNC_CLEAR: begin
              // Drop every row at once
              row_vld_nxt = '0;
              state_nxt   = S_DONE;
            end
            FUNC_INSERT: state_nxt = S_MPOS;
            FUNC_READ:   state_nxt = S_RT1;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_MPOS: state_nxt = S_ADD;
      S_ADD: begin
        if (sum_ax[25]) begin
          res_nxt.status = STAT_RANGE;
          state_nxt      = S_DONE;
        end else begin
          v_nxt     = sum_ax[23:0];
          state_nxt = S_MREC;
        end
      end
      S_MREC: state_nxt = S_MQN;
      S_MQN:  state_nxt = S_MOD;
      S_MOD: begin
        coord_nxt[axis_r] = (rem_ax >= {1'b0, n_sel}) ?
                            CoordW'(rem_ax - {1'b0, n_sel}) : CoordW'(rem_ax);
        if (axis_r == 2'd2) begin
          state_nxt = S_IX1;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_MPOS;
        end
      end
      S_IX1: state_nxt = S_IX2;
      S_IX2: state_nxt = S_CRD;
      S_CRD: begin
        idx_nxt            = idx_c;
        cnt_raddr          = idx_c[CellIdxW-1:LaneW];
        res_nxt.cell_x     = coord_r[0];
        res_nxt.cell_y     = coord_r[1];
        res_nxt.cell_z     = coord_r[2];
        res_nxt.cell_index = idx_c;
        state_nxt          = S_CWR;
      end
      S_CWR: begin
        if (cnt_cur[CountW-1]) begin
          res_nxt.cell_count = cnt_cur;
          res_nxt.status     = STAT_FULL;
        end else begin
          // Rebuild the row from zero if it is stale since the last clear
          cnt_wdata = row_vld_r[idx_r[CellIdxW-1:LaneW]] ? cnt_rd_r : '0;
          cnt_wdata[idx_r[LaneW-1:0]] = cnt_cur + CountW'(1);
          cnt_we      = 1'b1;
          row_vld_nxt[idx_r[CellIdxW-1:LaneW]] = 1'b1;
          mem_addr    = {idx_r, cnt_cur[SlotW-1:0]};
          mem_we      = 1'b1;
          res_nxt.slot       = cnt_cur[SlotW-1:0];
          res_nxt.cell_count = cnt_cur + CountW'(1);
        end
        state_nxt = S_DONE;
      end
      S_RT1: state_nxt = S_RT2;
      S_RT2: state_nxt = S_RCMP;
      S_RCMP: begin
        res_nxt.cell_index = in_r.read_cell;
        res_nxt.slot       = in_r.read_slot;
        state_nxt          = S_RCNT;
      end
      S_RCNT: begin
        if ({1'b0, in_r.read_cell} >= prod_r[CellIdxW:0]) begin
          res_nxt.status = STAT_RANGE;
          state_nxt      = S_DONE;
        end else begin
          res_nxt.cell_count = cnt_cur;
          if ({1'b0, in_r.read_slot} >= cnt_cur) begin
            res_nxt.status = STAT_RANGE;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_RMEM;
          end
        end
      end
      S_RMEM: begin
        res_nxt.member = mem_rd_r;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        // Advance once the output register is free
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      row_vld_r <= '0;
      axis_r    <= 2'd0;
    end else begin
      state_r   <= state_nxt;
      row_vld_r <= row_vld_nxt;
      axis_r    <= axis_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    res_r   <= res_nxt;
    coord_r <= coord_nxt;
    v_r     <= v_nxt;
    idx_r   <= idx_nxt;
  end

  // Output register: hold a result until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_r <= res_r;
    end
  end

  // Count memory: one row of 16 counts, registered read
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[idx_r[CellIdxW-1:LaneW]] <= cnt_wdata;
    end
    cnt_rd_r <= cnt_mem[cnt_raddr];
  end

  // Member memory: 16 slots per cell, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_addr] <= in_r.particle;
    end
    mem_rd_r <= mem_r[mem_addr];
  end

endmodule

// File: design/clb_checker.sv
`timescale 1ns / 1ps

module clb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input clb_pkg::clb_out_t            out_data
);
  import clb_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // One item at a time: no second input transfer right after one
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  // A full cell reports the capacity and slot zero
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_FULL |->
      out_data.cell_count == CountW'(CellCapacity) && out_data.slot == '0)
    else $error("full-cell result malformed");

  // No member is returned with a range error
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == STAT_RANGE |-> out_data.member == '0)
    else $error("member returned with range error");

endmodule

bind cell_list_binning_core clb_checker u_clb_checker (.*);
